// ----- sv/fcd_pkg.sv -----
package fcd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W  = 13;                    // grid_width / grid_height registers
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int IDX_W  = 24;
  localparam int VAL_W  = 8;
  localparam int PROD_W = ROW_W + DIM_W;
  localparam int WIN_N  = 9;
  localparam int WIN_CENTER = 4;

  localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(3);

  // register indexes on the config port
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef logic [1:0] cls_t;
  localparam cls_t CLS_FREE     = 2'd0;
  localparam cls_t CLS_UNKNOWN  = 2'd1;
  localparam cls_t CLS_OCCUPIED = 2'd2;

  localparam logic signed [VAL_W-1:0] VAL_UNKNOWN = -8'sd1;
  localparam logic signed [VAL_W-1:0] VAL_FREE    = 8'sd0;

  // classes of the two rows above, read from the line stores
  typedef struct packed {
    cls_t up1;
    cls_t up2;
  } lb_rd_t;

  function automatic cls_t classify(input logic signed [VAL_W-1:0] v);
    cls_t c;
    if (v == VAL_UNKNOWN) c = CLS_UNKNOWN;
    else if (v == VAL_FREE) c = CLS_FREE;
    else c = CLS_OCCUPIED;
    return c;
  endfunction

endpackage

// ----- sv/fcd_line_buf.sv -----
module fcd_line_buf import fcd_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  cls_t             wr_cls,
  input  cls_t             wr_up1,
  output lb_rd_t           rd_data
);

  cls_t store_a [MAX_WIDTH];   // row r-1
  cls_t store_b [MAX_WIDTH];   // row r-2
  cls_t rd_a_r;
  cls_t rd_b_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= store_a[rd_addr];
      rd_b_r <= store_b[rd_addr];
    end
  end

  // row r-1 shifts down to r-2, new class goes into r-1
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_a[wr_addr] <= wr_cls;
      store_b[wr_addr] <= wr_up1;
    end
  end

  assign rd_data.up1 = rd_a_r;
  assign rd_data.up2 = rd_b_r;

endmodule

// ----- sv/fcd_window.sv -----
module fcd_window import fcd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  cls_t             cls,
  input  lb_rd_t           rd_data,
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  output logic             hit
);

  // cell r*3+c, rows top (r-2) to bottom (r), columns left to right
  cls_t win_r   [WIN_N];
  cls_t win_nxt [WIN_N];
  logic unk_any;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 2; c++) begin
        win_nxt[r*3+c] = win_r[r*3+c+1];
      end
    end
    win_nxt[2] = rd_data.up2;
    win_nxt[5] = rd_data.up1;
    win_nxt[8] = cls;
  end

  always_comb begin
    unk_any = 1'b0;
    for (int i = 0; i < WIN_N; i++) begin
      if (i != WIN_CENTER && win_nxt[i] == CLS_UNKNOWN) unk_any = 1'b1;
    end
  end

  // border rows/columns never qualify: the center lags by one row and one column
  assign hit = (col >= COL_W'(2)) && (row >= ROW_W'(2)) &&
               (win_nxt[WIN_CENTER] == CLS_FREE) && unk_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_N; i++) win_r[i] <= CLS_FREE;
    end else if (adv) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ----- sv/frontier_cell_detector_core.sv -----
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_cell_value
// out_     output     out_valid/out_stall out_cell_column, out_cell_row, out_cell_index
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One cell per clock sustained while in_stall is low; after its lower-right neighbor
// is taken, a frontier result passes the input stage (with line store read), then
// window check and index multiply into the output register.
// Synchronous active-low reset clears counters, window and valids; line stores are
// not cleared. in_stall rises only while the output register holds a result that is
// stalled and the input stage is full.
module frontier_cell_detector_core import fcd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_cell_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [COL_W-1:0]        out_cell_column,
  output logic [ROW_W-1:0]        out_cell_row,
  output logic [IDX_W-1:0]        out_cell_index,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data
);

  logic [DIM_W-1:0] grid_width_r, grid_height_r;
  logic [DIM_W-1:0] w_eff, h_eff;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  cls_t             s1_cls_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;

  logic             out_valid_r, out_valid_nxt;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic [IDX_W-1:0] out_idx_r;

  logic             accept, move, out_free, hit;
  lb_rd_t           rd_data;
  logic [COL_W-1:0] fc;
  logic [ROW_W-1:0] fr;
  logic [PROD_W-1:0] idx_sum;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(MAX_WIDTH);
      grid_height_r <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (grid_width_r < MIN_DIM) w_eff = MIN_DIM;
    else if (grid_width_r > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = grid_width_r;
    if (grid_height_r < MIN_DIM) h_eff = MIN_DIM;
    else if (grid_height_r > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = grid_height_r;
  end

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign move     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !move;
  assign accept   = in_valid && !in_stall;

  // raster position of the next request
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if ((DIM_W'(col_r) + DIM_W'(1)) >= w_eff) begin
        col_nxt = '0;
        if ((DIM_W'(row_r) + DIM_W'(1)) >= h_eff) row_nxt = '0;
        else row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  assign s1_valid_nxt = accept ? 1'b1 : (move ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls_r <= classify(in_cell_value);
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  fcd_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .wr_en   (move),
    .wr_addr (s1_col_r),
    .wr_cls  (s1_cls_r),
    .wr_up1  (rd_data.up1),
    .rd_data (rd_data)
  );

  fcd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (move),
    .cls     (s1_cls_r),
    .rd_data (rd_data),
    .col     (s1_col_r),
    .row     (s1_row_r),
    .hit     (hit)
  );

  // frontier cell sits one row up, one column left
  assign fc      = s1_col_r - COL_W'(1);
  assign fr      = s1_row_r - ROW_W'(1);
  assign idx_sum = PROD_W'(fr) * PROD_W'(w_eff) + PROD_W'(fc);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move && hit) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (move && hit) begin
      out_col_r <= fc;
      out_row_r <= fr;
      out_idx_r <= idx_sum[IDX_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_column = out_col_r;
  assign out_cell_row    = out_row_r;
  assign out_cell_index  = out_idx_r;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_rose_from_move: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(move))
    else $error("result appeared without an advancing item");

  a_no_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_col_r != '0 && out_row_r != '0))
    else $error("border cell reported");

  a_lb_addr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (move && accept) |-> (s1_col_r != col_r))
    else $error("line store read and write hit the same column");
`endif

endmodule
